// ===== design/ipv4rf_pkg.sv =====
package ipv4rf_pkg;

    localparam int unsigned MIN_HEADER_BYTES = 20;

    localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;
    localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [3:0]  VERSION_IPV4   = 4'd4;

    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
    localparam logic [15:0] ICMP_HDR_BYTES = 16'd8;

    localparam logic [3:0] VERDICT_TCP        = 4'd0;
    localparam logic [3:0] VERDICT_UDP        = 4'd1;
    localparam logic [3:0] VERDICT_ICMP_ECHO  = 4'd2;
    localparam logic [3:0] VERDICT_ICMP_OTHER = 4'd3;
    localparam logic [3:0] VERDICT_OTHER      = 4'd4;
    localparam logic [3:0] VERDICT_SHORT      = 4'd5;
    localparam logic [3:0] VERDICT_VERSION    = 4'd6;
    localparam logic [3:0] VERDICT_HDRLEN     = 4'd7;
    localparam logic [3:0] VERDICT_CHECKSUM   = 4'd8;
    localparam logic [3:0] VERDICT_NOT_OURS   = 4'd9;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } ipv4rf_in_t;

    typedef struct packed {
        logic [3:0]  verdict;
        logic [7:0]  protocol_number;
        logic [31:0] source_address;
        logic [15:0] payload_length;
        logic [5:0]  header_length;
    } ipv4rf_out_t;

    // header state as it stands once the current word is folded in
    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] running_sum;
        logic [7:0]  version_length;
        logic [15:0] ip_length;
        logic [7:0]  protocol;
        logic [31:0] source;
        logic [31:0] destination;
        logic [7:0]  first_payload;
    } ipv4rf_summary_t;

endpackage

// ===== design/ipv4rf_hdr_accum.sv =====
module ipv4rf_hdr_accum
    import ipv4rf_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  ipv4rf_in_t      word,
    output ipv4rf_summary_t summary
);

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [7:0]  held_high_reg, held_high_next;
    logic [7:0]  version_length_reg, version_length_next;
    logic [15:0] ip_length_reg, ip_length_next;
    logic [7:0]  protocol_reg, protocol_next;
    logic [31:0] source_reg, source_next;
    logic [31:0] destination_reg, destination_next;
    logic [7:0]  first_payload_reg, first_payload_next;

    logic [15:0] idx;
    logic [7:0]  b;
    logic [15:0] ihl;
    logic        in_header;
    logic [7:0]  held_upd;
    ipv4rf_summary_t upd;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] c);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, c};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    always_comb begin
        idx = byte_count_reg;
        b   = word.packet_byte;

        upd.version_length = (idx == 16'd0) ? b : version_length_reg;
        ihl       = {10'd0, upd.version_length[3:0], 2'b00};
        in_header = (idx < ihl) || (idx == 16'd0);

        held_upd = (in_header && !idx[0]) ? b : held_high_reg;
        upd.running_sum = (in_header && idx[0])
                        ? ones_add(running_sum_reg, {held_high_reg, b})
                        : running_sum_reg;

        upd.ip_length    = (idx == 16'd2 || idx == 16'd3)
                         ? {ip_length_reg[7:0], b} : ip_length_reg;
        upd.protocol     = (idx == 16'd9) ? b : protocol_reg;
        upd.source       = (idx >= 16'd12 && idx <= 16'd15)
                         ? {source_reg[23:0], b} : source_reg;
        upd.destination  = (idx >= 16'd16 && idx <= 16'd19)
                         ? {destination_reg[23:0], b} : destination_reg;
        upd.first_payload = (idx == ihl && idx >= 16'(MIN_HEADER_BYTES))
                          ? b : first_payload_reg;
        upd.byte_count   = (idx == COUNT_MAX) ? idx : idx + 16'd1;

        summary = upd;

        // everything clears once the last word of a packet is taken
        if (word.last_byte) begin
            byte_count_next     = '0;
            running_sum_next    = '0;
            held_high_next      = '0;
            version_length_next = '0;
            ip_length_next      = '0;
            protocol_next       = '0;
            source_next         = '0;
            destination_next    = '0;
            first_payload_next  = '0;
        end else begin
            byte_count_next     = upd.byte_count;
            running_sum_next    = upd.running_sum;
            held_high_next      = held_upd;
            version_length_next = upd.version_length;
            ip_length_next      = upd.ip_length;
            protocol_next       = upd.protocol;
            source_next         = upd.source;
            destination_next    = upd.destination;
            first_payload_next  = upd.first_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg     <= '0;
            running_sum_reg    <= '0;
            held_high_reg      <= '0;
            version_length_reg <= '0;
            ip_length_reg      <= '0;
            protocol_reg       <= '0;
            source_reg         <= '0;
            destination_reg    <= '0;
            first_payload_reg  <= '0;
        end else if (step) begin
            byte_count_reg     <= byte_count_next;
            running_sum_reg    <= running_sum_next;
            held_high_reg      <= held_high_next;
            version_length_reg <= version_length_next;
            ip_length_reg      <= ip_length_next;
            protocol_reg       <= protocol_next;
            source_reg         <= source_next;
            destination_reg    <= destination_next;
            first_payload_reg  <= first_payload_next;
        end
    end

endmodule

// ===== design/ipv4rf_classify.sv =====
module ipv4rf_classify
    import ipv4rf_pkg::*;
(
    input  ipv4rf_summary_t summary,
    input  logic [31:0]     own_address,
    output ipv4rf_out_t     result
);

    logic [5:0]  ihl;
    logic [15:0] ihl_wide;
    logic [15:0] payload;
    logic [3:0]  verdict;
    logic        is_echo;

    always_comb begin
        ihl      = {summary.version_length[3:0], 2'b00};
        ihl_wide = {10'd0, ihl};
        payload  = summary.ip_length - ihl_wide;
        is_echo  = (payload >= ICMP_HDR_BYTES) && (summary.byte_count > ihl_wide)
                && (summary.first_payload == ICMP_ECHO_REQ);

        priority if (summary.byte_count < 16'(MIN_HEADER_BYTES)) begin
            verdict = VERDICT_SHORT;
        end else if (summary.version_length[7:4] != VERSION_IPV4) begin
            verdict = VERDICT_VERSION;
        end else if (ihl_wide < 16'(MIN_HEADER_BYTES) || summary.byte_count < ihl_wide
                     || summary.ip_length < ihl_wide) begin
            verdict = VERDICT_HDRLEN;
        end else if (summary.running_sum != SUM_GOOD) begin
            verdict = VERDICT_CHECKSUM;
        end else if (summary.destination != own_address
                     && summary.destination != BROADCAST_ADDR) begin
            verdict = VERDICT_NOT_OURS;
        end else if (summary.protocol == PROTO_TCP) begin
            verdict = VERDICT_TCP;
        end else if (summary.protocol == PROTO_UDP) begin
            verdict = VERDICT_UDP;
        end else if (summary.protocol == PROTO_ICMP) begin
            verdict = is_echo ? VERDICT_ICMP_ECHO : VERDICT_ICMP_OTHER;
        end else begin
            verdict = VERDICT_OTHER;
        end

        result.verdict = verdict;
        if (verdict <= VERDICT_OTHER) begin
            result.protocol_number = summary.protocol;
            result.source_address  = summary.source;
            result.payload_length  = payload;
            result.header_length   = ihl;
        end else begin
            result.protocol_number = '0;
            result.source_address  = '0;
            result.payload_length  = '0;
            result.header_length   = '0;
        end
    end

endmodule

// ===== design/ipv4_receive_header_filter.sv =====
// IPv4 receive header check and filter.
// Input channel s_valid/s_ready/s_data carries one packet byte per word, in
// wire order, with last_byte set on the final byte. Output channel
// m_valid/m_ready/m_data carries one verdict per packet: the class (tcp, udp,
// icmp echo, other icmp, other protocol) or the drop reason, with protocol,
// source, payload length and header length (zeros when dropped).
// cfg_wr_en/cfg_wr_data write own_address; change it only between packets.
// Throughput: one byte per cycle sustained. Each word sits in an input
// register while the header state is updated, and the verdict of a last
// byte is then registered in the output register that drives m_valid.
// A stalled receiver holds the verdict in the output register; bytes that
// are not last keep flowing, and the last byte of the next packet waits in
// the input register, holding off further bytes, until the held verdict is taken.
// Reset (aresetn low, synchronous) clears own_address to zero, empties both
// registers and clears all header state.
module ipv4_receive_header_filter
    import ipv4rf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ipv4rf_in_t  s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output ipv4rf_out_t m_data,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    logic        in_valid_reg, in_valid_next;
    ipv4rf_in_t  in_word_reg;
    logic        out_valid_reg, out_valid_next;
    ipv4rf_out_t out_word_reg;
    logic [31:0] own_address_reg;

    logic            advance;
    logic            s_accept;
    ipv4rf_summary_t summary;
    ipv4rf_out_t     result;

    // a last byte only moves on when the output register has room
    assign advance  = in_valid_reg && (!in_word_reg.last_byte || !out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    ipv4rf_hdr_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .word    (in_word_reg),
        .summary (summary)
    );

    ipv4rf_classify u_classify (
        .summary     (summary),
        .own_address (own_address_reg),
        .result      (result)
    );

    always_comb begin
        in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance && in_word_reg.last_byte) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            own_address_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                own_address_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_word_reg <= s_data;
        end
        if (advance && in_word_reg.last_byte) begin
            out_word_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

// ===== design/ipv4rf_checker.sv =====
module ipv4rf_checker
    import ipv4rf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input ipv4rf_in_t  s_data,
    input logic        m_valid,
    input logic        m_ready,
    input ipv4rf_out_t m_data
);

    // held verdict must not change under stall
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("verdict changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.verdict <= VERDICT_NOT_OURS)
        else $error("verdict code out of range");

    // dropped packets report no header details
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.verdict >= VERDICT_SHORT |->
            m_data.protocol_number == '0 && m_data.source_address == '0
            && m_data.payload_length == '0 && m_data.header_length == '0)
        else $error("dropped packet carries header fields");

    // accepted packets have a legal word-aligned header length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.verdict <= VERDICT_OTHER |->
            m_data.header_length >= 6'(MIN_HEADER_BYTES)
            && m_data.header_length[1:0] == 2'b00)
        else $error("accepted packet with bad header length");

    // a verdict only follows an accepted last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_data.last_byte, 2)
            || $past(s_valid && s_ready && s_data.last_byte, 1) || !$past(s_ready))
        else $error("verdict without a last byte");

endmodule

bind ipv4_receive_header_filter ipv4rf_checker u_ipv4rf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== sim/ipv4rf_verdict_checker.sv =====
module ipv4rf_verdict_checker
    import ipv4rf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  ipv4rf_in_t  s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  ipv4rf_out_t m_data,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    output int          mismatches,
    output int          verdicts_pending,
    output int          verdicts_checked,
    output logic [9:0]  verdict_classes
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] host_address;
    logic [15:0] rx_count;
    logic [15:0] hdr_sum;
    logic [7:0]  hi_byte;
    logic [7:0]  ver_ihl;
    logic [15:0] tot_len;
    logic [7:0]  proto_f;
    logic [31:0] src_f;
    logic [31:0] dst_f;
    logic [7:0]  first_pl;

    ipv4rf_out_t expected_verdicts[$];
    int          fail_total;
    int          checked_total;
    logic [9:0]  classes_hit;

    function automatic logic [15:0] ones_fold(input logic [15:0] acc, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    task automatic clear_header();
        rx_count = '0;
        hdr_sum  = '0;
        hi_byte  = '0;
        ver_ihl  = '0;
        tot_len  = '0;
        proto_f  = '0;
        src_f    = '0;
        dst_f    = '0;
        first_pl = '0;
    endtask

    // advance the header state by one byte, queue a verdict on the last one
    task automatic fold_byte(input logic [7:0] b, input logic last);
        logic [15:0]  pos;
        int unsigned  hlen;
        logic [15:0]  plen;
        logic [3:0]   v;
        ipv4rf_out_t  r;
        pos = rx_count;
        if (pos == 0) ver_ihl = b;
        hlen = 4 * ver_ihl[3:0];
        if (pos < hlen || pos == 0) begin
            if (!pos[0]) hi_byte = b;
            else hdr_sum = ones_fold(hdr_sum, {hi_byte, b});
        end
        if (pos == 2 || pos == 3) tot_len = {tot_len[7:0], b};
        if (pos == 9) proto_f = b;
        if (pos >= 12 && pos <= 15) src_f = {src_f[23:0], b};
        if (pos >= 16 && pos <= 19) dst_f = {dst_f[23:0], b};
        if (pos == hlen && pos >= MIN_HEADER_BYTES) first_pl = b;
        if (rx_count != COUNT_MAX) rx_count = rx_count + 16'd1;
        if (last) begin
            r = '0;
            if (rx_count < MIN_HEADER_BYTES) v = VERDICT_SHORT;
            else if (ver_ihl[7:4] != VERSION_IPV4) v = VERDICT_VERSION;
            else if (hlen < MIN_HEADER_BYTES || rx_count < hlen || tot_len < hlen)
                v = VERDICT_HDRLEN;
            else if (hdr_sum != SUM_GOOD) v = VERDICT_CHECKSUM;
            else if (dst_f != host_address && dst_f != BROADCAST_ADDR) v = VERDICT_NOT_OURS;
            else begin
                plen = tot_len - hlen[15:0];
                case (proto_f)
                    PROTO_TCP: v = VERDICT_TCP;
                    PROTO_UDP: v = VERDICT_UDP;
                    PROTO_ICMP: begin
                        if (plen >= ICMP_HDR_BYTES && rx_count > hlen
                                && first_pl == ICMP_ECHO_REQ)
                            v = VERDICT_ICMP_ECHO;
                        else
                            v = VERDICT_ICMP_OTHER;
                    end
                    default: v = VERDICT_OTHER;
                endcase
                r.protocol_number = proto_f;
                r.source_address  = src_f;
                r.payload_length  = plen;
                r.header_length   = hlen[5:0];
            end
            r.verdict = v;
            expected_verdicts.push_back(r);
            clear_header();
        end
    endtask

    task automatic note_failure(input ipv4rf_out_t want, input ipv4rf_out_t got,
                                input logic orphan);
        fail_total++;
        if (fail_total <= 10) begin
            if (orphan)
                $display("%t unexpected verdict word: v=%0d proto=%0d src=%h plen=%0d hlen=%0d",
                         $realtime, got.verdict, got.protocol_number, got.source_address,
                         got.payload_length, got.header_length);
            else begin
                $display("%t verdict mismatch: want v=%0d proto=%0d src=%h plen=%0d hlen=%0d",
                         $realtime, want.verdict, want.protocol_number, want.source_address,
                         want.payload_length, want.header_length);
                $display("%t                      got v=%0d proto=%0d src=%h plen=%0d hlen=%0d",
                         $realtime, got.verdict, got.protocol_number, got.source_address,
                         got.payload_length, got.header_length);
            end
        end
    endtask

    always @(posedge aclk) begin
        ipv4rf_out_t want;
        if (!aresetn) begin
            host_address = '0;
            clear_header();
            expected_verdicts.delete();
            fail_total    = 0;
            checked_total = 0;
            classes_hit   = '0;
        end else begin
            if (cfg_wr_en) host_address = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    note_failure('0, m_data, 1'b1);
                end else begin
                    want = expected_verdicts.pop_front();
                    checked_total++;
                    if (m_data.verdict !== want.verdict
                            || m_data.protocol_number !== want.protocol_number
                            || m_data.source_address !== want.source_address
                            || m_data.payload_length !== want.payload_length
                            || m_data.header_length !== want.header_length)
                        note_failure(want, m_data, 1'b0);
                    else
                        classes_hit[want.verdict] = 1'b1;
                end
            end
            if (s_valid && s_ready) fold_byte(s_data.packet_byte, s_data.last_byte);
        end
        // published with nba so readers at this edge see settled values
        mismatches       <= fail_total;
        verdicts_pending <= expected_verdicts.size();
        verdicts_checked <= checked_total;
        verdict_classes  <= classes_hit;
    end

endmodule

// ===== sim/tb_ipv4_receive_header_filter.sv =====
module tb_ipv4_receive_header_filter;
    import ipv4rf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum {
        FLAW_NONE, FLAW_SHORT, FLAW_VERSION, FLAW_IHL_LOW,
        FLAW_TRUNCATED, FLAW_TOTLEN_LOW, FLAW_CHECKSUM
    } flaw_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY_FOURTH} rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    ipv4rf_in_t  s_data;
    logic        m_valid;
    logic        m_ready;
    ipv4rf_out_t m_data;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    int          mismatches;
    int          verdicts_pending;
    int          verdicts_checked;
    logic [9:0]  verdict_classes;

    logic [7:0]  frame[$];
    logic [31:0] host_addr;
    int          burst_left;
    bit          steady;
    bit          long_hold_request;
    int          bytes_sent;
    int          packets_sent;
    int          addr_writes;

    ipv4_receive_header_filter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    ipv4rf_verdict_checker verdict_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .mismatches       (mismatches),
        .verdicts_pending (verdicts_pending),
        .verdicts_checked (verdicts_checked),
        .verdict_classes  (verdict_classes)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver: changing stall patterns, plus one long hold on request
    initial begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       tick;
        m_ready   = 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (long_hold_request) begin
                hold_left = 400;
                long_hold_request = 1'b0;
            end
            if (mode_left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:         m_ready <= 1'b1;
                    RX_COIN:         m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:       m_ready <= ($urandom_range(0, 7) == 0);
                    RX_EVERY_FOURTH: m_ready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_valid <= 1'b1;
        s_data  <= {b, last};
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int k = 0; k < frame.size(); k++)
            push_byte(frame[k], k == frame.size() - 1);
        packets_sent++;
    endtask

    task automatic wait_for_verdicts();
        s_valid <= 1'b0;
        do @(posedge aclk); while (verdicts_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_host_address(input logic [31:0] addr);
        wait_for_verdicts();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        host_addr    = addr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        addr_writes++;
    endtask

    task automatic make_fill(input int len, input logic [7:0] value);
        frame.delete();
        repeat (len) frame.push_back(value);
    endtask

    // lead: first payload byte, or random when negative
    task automatic make_datagram(input logic [3:0] ihl, input logic [7:0] proto,
                                 input logic [31:0] dst, input int pay_bytes,
                                 input int sent_payload, input flaw_t flaw, input int lead);
        int          hbytes;
        int          gen_bytes;
        int          cut;
        logic [15:0] total;
        logic [3:0]  ver;
        logic [31:0] src;
        logic [16:0] acc;
        logic [15:0] hsum;
        frame.delete();
        hbytes    = 4 * ihl;
        gen_bytes = (hbytes < 20) ? 20 : hbytes;
        total     = 16'(hbytes + pay_bytes);
        if (flaw == FLAW_TOTLEN_LOW) total = 16'($urandom_range(0, hbytes - 1));
        ver = VERSION_IPV4;
        if (flaw == FLAW_VERSION)
            do ver = 4'($urandom_range(0, 15)); while (ver == VERSION_IPV4);
        src = $urandom;
        frame.push_back({ver, ihl});
        frame.push_back(8'($urandom_range(0, 255)));
        frame.push_back(total[15:8]);
        frame.push_back(total[7:0]);
        repeat (5) frame.push_back(8'($urandom_range(0, 255)));
        frame.push_back(proto);
        frame.push_back(8'h00);
        frame.push_back(8'h00);
        for (int k = 3; k >= 0; k--) frame.push_back(src[8*k +: 8]);
        for (int k = 3; k >= 0; k--) frame.push_back(dst[8*k +: 8]);
        repeat (gen_bytes - 20) frame.push_back(8'($urandom_range(0, 255)));
        hsum = '0;
        for (int k = 0; k < hbytes / 2; k++) begin
            acc  = {1'b0, hsum} + {1'b0, frame[2*k], frame[2*k+1]};
            hsum = acc[15:0] + {15'd0, acc[16]};
        end
        hsum = ~hsum;
        frame[10] = hsum[15:8];
        frame[11] = hsum[7:0];
        // a nonzero change to the high byte always breaks the folded sum
        if (flaw == FLAW_CHECKSUM) frame[10] = frame[10] ^ 8'($urandom_range(1, 255));
        for (int k = 0; k < sent_payload; k++) begin
            if (k == 0 && lead >= 0) frame.push_back(lead[7:0]);
            else frame.push_back(8'($urandom_range(0, 255)));
        end
        cut = frame.size();
        if (flaw == FLAW_TRUNCATED) cut = $urandom_range(20, hbytes - 1);
        if (flaw == FLAW_SHORT) cut = $urandom_range(1, 19);
        while (frame.size() > cut) void'(frame.pop_back());
    endtask

    task automatic make_random_datagram();
        flaw_t       flaw;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [31:0] dst;
        int          plen;
        int          sent;
        int          lead;
        int          pick;
        flaw = ($urandom_range(0, 9) < 6) ? FLAW_NONE : flaw_t'($urandom_range(1, 6));
        case (flaw)
            FLAW_IHL_LOW:   ihl = 4'($urandom_range(0, 4));
            FLAW_TRUNCATED: ihl = 4'($urandom_range(6, 15));
            FLAW_NONE:      ihl = $urandom_range(0, 1) ? 4'd5 : 4'($urandom_range(6, 15));
            default:        ihl = 4'($urandom_range(5, 15));
        endcase
        pick = $urandom_range(0, 7);
        case (pick)
            0, 1:    proto = PROTO_TCP;
            2:       proto = PROTO_UDP;
            3, 4:    proto = PROTO_ICMP;
            5:       proto = 8'($urandom_range(0, 255));
            6:       proto = 8'h00;
            default: proto = 8'hFF;
        endcase
        pick = $urandom_range(0, 9);
        if (pick <= 4) dst = host_addr;
        else if (pick <= 6) dst = BROADCAST_ADDR;
        else if (pick == 7) dst = $urandom;
        else if (pick == 8) dst = host_addr ^ (32'h1 << $urandom_range(0, 31));
        else dst = '0;
        if ($urandom_range(0, 9) == 0) begin
            // large total length, few bytes actually sent
            plen = $urandom_range(0, 65535 - 4 * ihl);
            sent = $urandom_range(0, 16);
        end else begin
            plen = $urandom_range(0, 24);
            sent = ($urandom_range(0, 9) < 7) ? plen : $urandom_range(0, plen + 8);
        end
        lead = (proto == PROTO_ICMP && $urandom_range(0, 3) != 0) ? int'(ICMP_ECHO_REQ) : -1;
        make_datagram(ihl, proto, dst, plen, sent, flaw, lead);
    endtask

    task automatic send_random_packet();
        steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 7) == 0) begin
            frame.delete();
            repeat ($urandom_range(1, 64)) frame.push_back(8'($urandom_range(0, 255)));
        end else begin
            make_random_datagram();
        end
        send_frame();
    endtask

    initial begin
        logic [31:0] phase_addr[4];
        int          phase_bytes;
        int          phase_packets;
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_data            = '0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        host_addr         = '0;
        burst_left        = 0;
        steady            = 1'b0;
        long_hold_request = 1'b0;
        bytes_sent        = 0;
        packets_sent      = 0;
        addr_writes       = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: host address still at its reset value of zero
        make_datagram(5, PROTO_TCP, 32'h0, 0, 0, FLAW_NONE, -1);
        send_frame();
        make_datagram(15, PROTO_UDP, BROADCAST_ADDR, 4, 4, FLAW_NONE, -1);
        send_frame();
        make_datagram(5, PROTO_ICMP, 32'h0, 8, 8, FLAW_NONE, ICMP_ECHO_REQ);
        send_frame();
        make_datagram(5, PROTO_ICMP, 32'h0, 7, 7, FLAW_NONE, ICMP_ECHO_REQ);
        send_frame();
        // echo type claimed by length but no payload byte received
        make_datagram(5, PROTO_ICMP, 32'h0, 12, 0, FLAW_NONE, -1);
        send_frame();
        make_datagram(5, PROTO_ICMP, 32'h0, 20, 20, FLAW_NONE, 0);
        send_frame();
        make_datagram(5, 8'hFF, 32'h0, 3, 3, FLAW_NONE, -1);
        send_frame();
        make_datagram(6, 8'h00, 32'h0, 0, 2, FLAW_NONE, -1);
        send_frame();
        make_fill(1, 8'h45);
        send_frame();
        make_fill(19, 8'h45);
        send_frame();
        make_fill(20, 8'hFF);
        send_frame();
        make_fill(20, 8'h00);
        send_frame();
        make_datagram(5, PROTO_TCP, 32'h0, 0, 0, FLAW_VERSION, -1);
        send_frame();
        make_datagram(0, PROTO_TCP, 32'h0, 0, 4, FLAW_IHL_LOW, -1);
        send_frame();
        make_datagram(4, PROTO_TCP, 32'h0, 0, 0, FLAW_IHL_LOW, -1);
        send_frame();
        make_datagram(9, PROTO_UDP, 32'h0, 0, 0, FLAW_TRUNCATED, -1);
        send_frame();
        make_datagram(5, PROTO_UDP, 32'h0, 0, 6, FLAW_TOTLEN_LOW, -1);
        send_frame();
        make_datagram(5, PROTO_TCP, 32'h0, 4, 4, FLAW_CHECKSUM, -1);
        send_frame();
        make_datagram(5, PROTO_TCP, 32'h1, 4, 4, FLAW_NONE, -1);
        send_frame();
        make_datagram(15, PROTO_TCP, 32'h0, 65535 - 60, 2, FLAW_NONE, -1);
        send_frame();

        phase_addr[0] = $urandom;
        phase_addr[1] = BROADCAST_ADDR;
        phase_addr[2] = $urandom;
        phase_addr[3] = 32'h0;
        for (int p = 0; p < 4; p++) begin
            set_host_address(phase_addr[p]);
            if (p == 1) begin
                // hold the result side while packets keep coming
                long_hold_request = 1'b1;
                repeat (8) begin
                    make_datagram(5, PROTO_TCP, host_addr, 4, 4, FLAW_NONE, -1);
                    send_frame();
                end
            end
            phase_bytes   = bytes_sent + 180;
            phase_packets = packets_sent + 4;
            while (bytes_sent < phase_bytes || packets_sent < phase_packets)
                send_random_packet();
        end

        wait_for_verdicts();
        repeat (8) @(posedge aclk);
        $display("covered %0d bytes in %0d packets, %0d verdicts compared, %0d address writes",
                 bytes_sent, packets_sent, verdicts_checked, addr_writes);
        $display("verdict classes hit (bit per class): %b", verdict_classes);
        if (mismatches == 0 && verdicts_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
